### rtl/core/timed_event_queue_core_assert.svh
// ----------------------------------------------------------------------------
// timed event queue assertion macros
// concurrent assertion helpers clocked on clk with reset qualification
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_CORE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_CORE_ASSERT_SVH

// assertion checked on every rising edge outside reset
`define TEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the following edge
`define TEQ_ASSERT_NEXT(label, cond, prop, msg) \
    `TEQ_ASSERT(label, (cond) |=> (prop), msg)

`endif

### rtl/core/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// shared types and constants of the timed event queue
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_RESULTS = 64;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] KIND_ADD     = 3'd0;
    localparam logic [2:0] KIND_DEL_ONE = 3'd1;
    localparam logic [2:0] KIND_DEL_ALL = 3'd2;
    localparam logic [2:0] KIND_ADVANCE = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    localparam logic [2:0] EV_ONE_TIME  = 3'd0;
    localparam logic [2:0] EV_RANGED    = 3'd1;
    localparam logic [2:0] EV_END_RANGE = 3'd2;
    localparam logic [2:0] EV_PERIODIC  = 3'd3;
    localparam logic [2:0] EV_DAILY     = 3'd4;

    localparam logic REG_DELETION_LOCK   = 1'b0;
    localparam logic REG_SECONDS_PER_DAY = 1'b1;

    localparam logic [31:0] DAY_RESET = 32'd86400;

    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  id;
        logic [31:0] param;
        logic [2:0]  etype;
        logic [31:0] offset;
        logic        marked;
    } teq_entry_t;

    typedef enum logic [3:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR,
        CELL_SCAN,
        CELL_MATCH_ALL,
        CELL_MARK_SWEEP,
        CELL_COMPACT,
        CELL_DROP
    } teq_cell_op_t;

    typedef struct packed {
        teq_cell_op_t op;
        logic         lock;
        logic         phase;
        logic [7:0]   key_id;
        logic [31:0]  key_param;
        teq_entry_t   new_entry;
    } teq_cell_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_DEL_ALL,
        ST_COMPACT,
        ST_ACK,
        ST_ADV_CHECK,
        ST_ADV_POP,
        ST_ADV_REPOST,
        ST_FINAL
    } teq_state_t;

endpackage

### rtl/core/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell
// one queue slot: holds an entry and trades it with its neighbors
// ----------------------------------------------------------------------------
module teq_cell import teq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  teq_cell_ctl_t ctl,
    input  logic          odd,
    input  teq_entry_t    prev_entry,
    input  logic          prev_valid,
    input  logic          prev_le,
    input  logic          prev_kill,
    input  logic          prev_tok,
    input  teq_entry_t    next_entry,
    input  logic          next_valid,
    input  logic          next_kill,
    output teq_entry_t    entry,
    output logic          valid,
    output logic          kill,
    output logic          le,
    output logic          tok_out,
    output logic          hit
);

    teq_entry_t entry_reg, entry_next;
    logic valid_reg, valid_next;
    logic kill_reg, kill_next;
    logic tok_reg, tok_next;
    logic match_one, match_id, left_side;

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign kill  = kill_reg;
    assign le    = valid_reg && (entry_reg.stamp <= ctl.new_entry.stamp);

    assign match_id  = valid_reg && !entry_reg.marked && (entry_reg.id == ctl.key_id);
    assign match_one = match_id && (entry_reg.param == ctl.key_param);
    assign tok_out   = tok_reg && valid_reg && !match_one;
    assign hit       = (ctl.op == CELL_SCAN) ? (tok_reg && match_one) : match_id;
    assign left_side = (odd == ctl.phase);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        kill_next  = kill_reg;
        tok_next   = tok_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (!le)
                begin
                    entry_next = prev_le ? ctl.new_entry : prev_entry;
                    valid_next = valid_reg || prev_valid;
                end
            end
            CELL_SHIFT:
            begin
                entry_next = next_entry;
                valid_next = next_valid;
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
                kill_next  = 1'b0;
                tok_next   = 1'b0;
            end
            CELL_SCAN:
            begin
                tok_next = prev_tok;
                if (tok_reg && match_one)
                begin
                    if (ctl.lock)
                        entry_next.marked = 1'b1;
                    else
                        kill_next = 1'b1;
                end
            end
            CELL_MATCH_ALL:
            begin
                if (match_id)
                begin
                    if (ctl.lock)
                        entry_next.marked = 1'b1;
                    else
                        kill_next = 1'b1;
                end
            end
            CELL_MARK_SWEEP:
            begin
                kill_next = valid_reg && entry_reg.marked;
            end
            CELL_COMPACT:
            begin
                if (left_side)
                begin
                    if (kill_reg && next_valid && !next_kill)
                    begin
                        entry_next = next_entry;
                        kill_next  = 1'b0;
                    end
                end
                else if (prev_kill && valid_reg && !kill_reg)
                begin
                    entry_next = prev_entry;
                    kill_next  = 1'b1;
                end
            end
            CELL_DROP:
            begin
                valid_next = valid_reg && !kill_reg;
                kill_next  = 1'b0;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            kill_reg  <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            kill_reg  <= kill_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/core/timed_event_queue_core.sv
// ----------------------------------------------------------------------------
// timed_event_queue_core
// timestamp-sorted event queue built as a chain of slot cells
// ----------------------------------------------------------------------------
// channel   dir  tuser        tdata (low bit first)                      tlast
// s_axis    in   kind[2:0]    type,id,param,time,offset,advance_by       -
// m_axis    out  fired        ok,id,param,type,time,clock_now            last
// cfg       in   -            cfg_index 0 deletion_lock, 1 sec_per_day   -
//
// add: insert, then acknowledge; delete: token scan plus odd-even
// compaction through the cell chain; clear: empty cells, then acknowledge;
// advance: pop each fired event, repost it if it recurs; sweep when due.
// reset empties the queue and clears the clock; entries need no clearing.
// one item is in work at a time; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module timed_event_queue_core import teq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [2:0]   s_tuser,   // kind
    input  logic [143:0] s_tdata,   // type, id, param, time, offset, advance_by
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,   // fired
    output logic [111:0] m_tdata,   // ok, id, param, type, time, clock_now
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    teq_state_t state_reg, state_next;

    logic        lock_reg;
    logic [31:0] day_reg;
    logic [31:0] clock_reg, clock_next;
    logic [31:0] target_reg, target_next;
    logic        sweep_reg, sweep_next;
    logic        ok_reg, ok_next;
    logic [7:0]  key_id_reg, key_id_next;
    logic [31:0] key_param_reg, key_param_next;
    teq_entry_t  new_reg, new_next;
    logic        rep_ok_reg, rep_ok_next;
    logic        pend_reg, pend_next;
    teq_entry_t  pend_entry_reg, pend_entry_next;
    logic [31:0] pend_clock_reg, pend_clock_next;
    logic [NCNT_W-1:0] n_reg, n_next;
    logic        ret_final_reg, ret_final_next;
    logic        phase_reg, phase_next;
    logic        start_reg, start_next;

    logic         m_valid_reg, m_valid_next;
    logic         m_fired_reg, m_fired_next;
    logic         m_last_reg, m_last_next;
    logic [107:0] m_data_reg, m_data_next;

    teq_cell_ctl_t ctl;
    teq_entry_t entry_vec [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec, kill_vec, le_vec, tok_vec, hit_vec;
    logic [QUEUE_DEPTH-1:0] bubble_vec;

    logic [2:0]  in_kind, in_type;
    logic [7:0]  in_id;
    logic [31:0] in_param, in_time, in_off, in_adv;
    logic [32:0] adv_sum;
    logic        accept, out_free, full, due, bubble;
    teq_entry_t  head;
    logic [31:0] fire_clock, rep_step;
    logic [32:0] rep_sum;
    logic [2:0]  rep_type;
    logic [31:0] rep_off;
    logic        rep_kind;

    assign in_kind  = s_tuser;
    assign in_type  = s_tdata[2:0];
    assign in_id    = s_tdata[10:3];
    assign in_param = s_tdata[42:11];
    assign in_time  = s_tdata[74:43];
    assign in_off   = s_tdata[106:75];
    assign in_adv   = s_tdata[138:107];
    assign adv_sum  = {1'b0, clock_reg} + {1'b0, in_adv};

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_fired_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_data_reg};

    assign full   = valid_vec[QUEUE_DEPTH-1];
    assign head   = entry_vec[0];
    assign due    = valid_vec[0] && (head.stamp <= target_reg)
                    && (n_reg < NCNT_W'(MAX_RESULTS));
    assign bubble = |bubble_vec;
    assign fire_clock = (head.stamp > clock_reg) ? head.stamp : clock_reg;

    always_comb
    begin
        rep_kind = 1'b1;
        rep_type = head.etype;
        rep_step = 32'd0;
        rep_off  = 32'd0;
        case (head.etype)
            EV_RANGED:
            begin
                rep_type = EV_END_RANGE;
                rep_step = head.offset;
            end
            EV_PERIODIC:
            begin
                rep_step = head.offset;
                rep_off  = head.offset;
            end
            EV_DAILY:
            begin
                rep_step = day_reg;
            end
            default:
            begin
                rep_kind = 1'b0;
            end
        endcase
    end
    assign rep_sum = {1'b0, head.stamp} + {1'b0, rep_step};

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            teq_entry_t p_entry, n_entry;
            logic p_valid, p_le, p_kill, p_tok, n_valid, n_kill;
            if (gi == 0)
            begin : g_first
                assign p_entry = entry_vec[0];
                assign p_valid = 1'b1;
                assign p_le    = 1'b1;
                assign p_kill  = 1'b0;
                assign p_tok   = start_reg;
            end
            else
            begin : g_inner
                assign p_entry = entry_vec[gi-1];
                assign p_valid = valid_vec[gi-1];
                assign p_le    = le_vec[gi-1];
                assign p_kill  = kill_vec[gi-1];
                assign p_tok   = tok_vec[gi-1];
            end
            if (gi == QUEUE_DEPTH-1)
            begin : g_last
                assign n_entry = entry_vec[gi];
                assign n_valid = 1'b0;
                assign n_kill  = 1'b0;
                assign bubble_vec[gi] = 1'b0;
            end
            else
            begin : g_body
                assign n_entry = entry_vec[gi+1];
                assign n_valid = valid_vec[gi+1];
                assign n_kill  = kill_vec[gi+1];
                assign bubble_vec[gi] = kill_vec[gi] && valid_vec[gi+1] && !kill_vec[gi+1];
            end
            teq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .odd        (1'(gi % 2)),
                .prev_entry (p_entry),
                .prev_valid (p_valid),
                .prev_le    (p_le),
                .prev_kill  (p_kill),
                .prev_tok   (p_tok),
                .next_entry (n_entry),
                .next_valid (n_valid),
                .next_kill  (n_kill),
                .entry      (entry_vec[gi]),
                .valid      (valid_vec[gi]),
                .kill       (kill_vec[gi]),
                .le         (le_vec[gi]),
                .tok_out    (tok_vec[gi]),
                .hit        (hit_vec[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_kind)
                        KIND_ADD:     state_next = full ? ST_ACK : ST_INSERT;
                        KIND_DEL_ONE: state_next = ST_SCAN;
                        KIND_DEL_ALL: state_next = ST_DEL_ALL;
                        KIND_ADVANCE: state_next = ST_ADV_CHECK;
                        default:      state_next = ST_ACK;
                    endcase
                end
            end
            ST_INSERT:  state_next = ST_ACK;
            ST_SCAN:    state_next = (!start_reg && !(|tok_vec)) ? ST_COMPACT : ST_SCAN;
            ST_DEL_ALL: state_next = ST_COMPACT;
            ST_COMPACT:
            begin
                if (!bubble)
                    state_next = ret_final_reg ? ST_FINAL : ST_ACK;
            end
            ST_ACK:     state_next = out_free ? ST_IDLE : ST_ACK;
            ST_ADV_CHECK:
            begin
                if (due)
                begin
                    if (!pend_reg || out_free)
                        state_next = ST_ADV_POP;
                end
                else
                    state_next = sweep_reg ? ST_COMPACT : ST_FINAL;
            end
            ST_ADV_POP:    state_next = rep_ok_reg ? ST_ADV_REPOST : ST_ADV_CHECK;
            ST_ADV_REPOST: state_next = ST_ADV_CHECK;
            ST_FINAL:      state_next = out_free ? ST_IDLE : ST_FINAL;
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath and cell control
    always_comb
    begin
        clock_next      = clock_reg;
        target_next     = target_reg;
        sweep_next      = sweep_reg;
        ok_next         = ok_reg;
        key_id_next     = key_id_reg;
        key_param_next  = key_param_reg;
        new_next        = new_reg;
        rep_ok_next     = rep_ok_reg;
        pend_next       = pend_reg;
        pend_entry_next = pend_entry_reg;
        pend_clock_next = pend_clock_reg;
        n_next          = n_reg;
        ret_final_next  = ret_final_reg;
        phase_next      = phase_reg;
        start_next      = 1'b0;
        m_valid_next    = m_valid_reg && !m_tready;
        m_fired_next    = m_fired_reg;
        m_last_next     = m_last_reg;
        m_data_next     = m_data_reg;

        ctl.op        = CELL_HOLD;
        ctl.lock      = lock_reg;
        ctl.phase     = phase_reg;
        ctl.key_id    = key_id_reg;
        ctl.key_param = key_param_reg;
        ctl.new_entry = new_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_id_next     = in_id;
                    key_param_next  = in_param;
                    new_next.stamp  = in_time;
                    new_next.id     = in_id;
                    new_next.param  = in_param;
                    new_next.etype  = in_type;
                    new_next.offset = (in_type == EV_RANGED || in_type == EV_PERIODIC)
                                      ? in_off : 32'd0;
                    new_next.marked = 1'b0;
                    ok_next         = 1'b0;
                    ret_final_next  = 1'b0;
                    phase_next      = 1'b0;
                    start_next      = (in_kind == KIND_DEL_ONE);
                    n_next          = '0;
                    pend_next       = 1'b0;
                    target_next     = adv_sum[32] ? 32'hFFFF_FFFF : adv_sum[31:0];
                    if (in_kind == KIND_CLEAR)
                    begin
                        ctl.op     = CELL_CLEAR;
                        sweep_next = 1'b0;
                        ok_next    = 1'b1;
                    end
                end
            end
            ST_INSERT:
            begin
                ctl.op  = CELL_INSERT;
                ok_next = 1'b1;
            end
            ST_SCAN:
            begin
                ctl.op = CELL_SCAN;
                if (|hit_vec)
                begin
                    if (lock_reg)
                        sweep_next = 1'b1;
                    else
                        ok_next = 1'b1;
                end
            end
            ST_DEL_ALL:
            begin
                ctl.op = CELL_MATCH_ALL;
                if (|hit_vec)
                begin
                    if (lock_reg)
                        sweep_next = 1'b1;
                    else
                        ok_next = 1'b1;
                end
            end
            ST_COMPACT:
            begin
                ctl.op     = bubble ? CELL_COMPACT : CELL_DROP;
                phase_next = !phase_reg;
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_fired_next = 1'b0;
                    m_last_next  = 1'b1;
                    m_data_next  = {clock_reg, 75'd0, ok_reg};
                end
            end
            ST_ADV_CHECK:
            begin
                if (due)
                begin
                    if (!pend_reg || out_free)
                    begin
                        if (pend_reg)
                        begin
                            m_valid_next = 1'b1;
                            m_fired_next = 1'b1;
                            m_last_next  = 1'b0;
                            m_data_next  = {pend_clock_reg, pend_entry_reg.stamp,
                                            pend_entry_reg.etype, pend_entry_reg.param,
                                            pend_entry_reg.id, !pend_entry_reg.marked};
                        end
                        clock_next      = fire_clock;
                        pend_next       = 1'b1;
                        pend_entry_next = head;
                        pend_clock_next = fire_clock;
                        n_next          = n_reg + NCNT_W'(1);
                        rep_ok_next     = rep_kind && (rep_step != 32'd0) && !rep_sum[32];
                        new_next.stamp  = rep_sum[31:0];
                        new_next.id     = head.id;
                        new_next.param  = head.param;
                        new_next.etype  = rep_type;
                        new_next.offset = rep_off;
                        new_next.marked = 1'b0;
                    end
                end
                else if (sweep_reg)
                begin
                    ctl.op         = CELL_MARK_SWEEP;
                    sweep_next     = 1'b0;
                    ret_final_next = 1'b1;
                    phase_next     = 1'b0;
                end
            end
            ST_ADV_POP:
            begin
                ctl.op = CELL_SHIFT;
            end
            ST_ADV_REPOST:
            begin
                ctl.op = CELL_INSERT;
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    clock_next   = target_reg;
                    m_valid_next = 1'b1;
                    m_fired_next = pend_reg;
                    m_last_next  = 1'b1;
                    if (pend_reg)
                        m_data_next = {target_reg, pend_entry_reg.stamp,
                                       pend_entry_reg.etype, pend_entry_reg.param,
                                       pend_entry_reg.id, !pend_entry_reg.marked};
                    else
                        m_data_next = {target_reg, 75'd0, 1'b1};
                end
            end
            default:
            begin
                ctl.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lock_reg    <= 1'b0;
            day_reg     <= DAY_RESET;
            clock_reg   <= 32'd0;
            sweep_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            start_reg   <= 1'b0;
            n_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            start_reg   <= start_next;
            n_reg       <= n_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_DELETION_LOCK)
                    lock_reg <= cfg_data[0];
                else
                    day_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        ok_reg         <= ok_next;
        key_id_reg     <= key_id_next;
        key_param_reg  <= key_param_next;
        new_reg        <= new_next;
        rep_ok_reg     <= rep_ok_next;
        pend_entry_reg <= pend_entry_next;
        pend_clock_reg <= pend_clock_next;
        ret_final_reg  <= ret_final_next;
        phase_reg      <= phase_next;
        m_fired_reg    <= m_fired_next;
        m_last_reg     <= m_last_next;
        m_data_reg     <= m_data_next;
    end

endmodule

### rtl/core/teq_checker.sv
// ----------------------------------------------------------------------------
// teq_checker
// port-level checks of the timed event queue, bound to the top level
// ----------------------------------------------------------------------------
`include "timed_event_queue_core_assert.svh"

module teq_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         m_tuser,
    input logic         m_tlast,
    input logic [111:0] m_tdata
);

    `TEQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `TEQ_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken during work")
    `TEQ_ASSERT(a_ack_last, m_tvalid && !m_tuser |-> m_tlast, "acknowledgement not last")
    `TEQ_ASSERT(a_ack_zero, m_tvalid && !m_tuser |-> m_tdata[75:1] == 75'd0, "ack fields set")

endmodule

bind timed_event_queue_core teq_checker u_teq_checker (.*);

### dv/timed_event_queue_core_tb.sv
// ----------------------------------------------------------------------------
// timed_event_queue_core_tb
// stream-driven check of the timestamp-ordered event queue: a scoreboard
// keeps its own sorted queue, clock and sweep state, predicts every
// acknowledgement and fired event, and compares each output transfer in order
// ----------------------------------------------------------------------------
module timed_event_queue_core_tb import teq_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_BAD_LO = 3'd5;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;
    localparam logic [31:0] MAX_STAMP = 32'hFFFF_FFFF;
    localparam int LIMIT_CYCLES = 2_000_000;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  etype;
        logic [7:0]  id;
        logic [31:0] param;
        logic [31:0] stamp;
        logic [31:0] offset;
        logic [31:0] adv;
    } sched_cmd_t;

    typedef struct packed {
        logic        fired;
        logic        ok;
        logic [7:0]  id;
        logic [31:0] param;
        logic [2:0]  etype;
        logic [31:0] stamp;
        logic [31:0] clk_now;
        logic        last;
    } sched_res_t;

    class event_scoreboard;
        teq_entry_t  slots[QUEUE_DEPTH];
        int          count;
        logic [31:0] clock;
        logic        sweep;
        logic        lock;
        logic [31:0] day_len;
        sched_res_t  due_q[$];
        int          errors;

        function void init();
            count = 0;
            clock = 0;
            sweep = 0;
            lock = 0;
            day_len = DAY_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_DELETION_LOCK)
                lock = val[0];
            else
                day_len = val;
        endfunction

        function void drop_slot(int pos);
            for (int i = pos; i + 1 < count; i++)
                slots[i] = slots[i + 1];
            count--;
        endfunction

        function logic place(logic [2:0] t, logic [7:0] id, logic [31:0] p,
                             logic [31:0] s, logic [31:0] off);
            int pos;
            pos = 0;
            if (count >= QUEUE_DEPTH)
                return 1'b0;
            while (pos < count && slots[pos].stamp <= s)
                pos++;
            for (int i = count; i > pos; i--)
                slots[i] = slots[i - 1];
            slots[pos] = '{stamp: s, id: id, param: p, etype: t, offset: off, marked: 1'b0};
            count++;
            return 1'b1;
        endfunction

        function void ack(logic ok);
            due_q.push_back('{1'b0, ok, 8'd0, 32'd0, 3'd0, 32'd0, clock, 1'b1});
        endfunction

        function void run_clock(logic [31:0] adv);
            logic [32:0] target;
            logic [32:0] sum;
            logic [31:0] step, noff;
            logic [2:0]  ntype;
            logic        repost;
            teq_entry_t  e;
            sched_res_t  fired_q[$];
            target = {1'b0, clock} + adv;
            if (target > {1'b0, MAX_STAMP})
                target = {1'b0, MAX_STAMP};
            while (fired_q.size() < MAX_RESULTS && count > 0
                   && {1'b0, slots[0].stamp} <= target) begin
                e = slots[0];
                if (e.stamp > clock)
                    clock = e.stamp;
                drop_slot(0);
                repost = 1'b1;
                step = 0;
                noff = 0;
                ntype = EV_ONE_TIME;
                if (e.etype == EV_RANGED) begin
                    ntype = EV_END_RANGE;
                    step = e.offset;
                end else if (e.etype == EV_PERIODIC) begin
                    ntype = EV_PERIODIC;
                    step = e.offset;
                    noff = e.offset;
                end else if (e.etype == EV_DAILY) begin
                    ntype = EV_DAILY;
                    step = day_len;
                end else
                    repost = 1'b0;
                sum = {1'b0, e.stamp} + step;
                if (repost && step != 0 && sum <= {1'b0, MAX_STAMP})
                    void'(place(ntype, e.id, e.param, sum[31:0], noff));
                fired_q.push_back('{1'b1, !e.marked, e.id, e.param, e.etype, e.stamp,
                                    clock, 1'b0});
            end
            if (sweep)
                begin
                    int w;
                    w = 0;
                    for (int r = 0; r < count; r++)
                        if (!slots[r].marked)
                            slots[w++] = slots[r];
                    count = w;
                    sweep = 0;
                end
            clock = target[31:0];
            if (fired_q.size() == 0) begin
                ack(1'b1);
                return;
            end
            fired_q[fired_q.size() - 1].clk_now = clock;
            fired_q[fired_q.size() - 1].last = 1'b1;
            foreach (fired_q[i])
                due_q.push_back(fired_q[i]);
        endfunction

        function void note_cmd(sched_cmd_t c);
            logic ok;
            int   i;
            ok = 0;
            case (c.kind)
                KIND_ADVANCE: begin
                    run_clock(c.adv);
                    return;
                end
                KIND_ADD:
                    ok = place(c.etype, c.id, c.param, c.stamp,
                               (c.etype == EV_RANGED || c.etype == EV_PERIODIC) ?
                               c.offset : 32'd0);
                KIND_DEL_ONE:
                    for (i = 0; i < count; i++)
                        if (slots[i].id == c.id && slots[i].param == c.param
                            && !slots[i].marked) begin
                            if (lock) begin
                                slots[i].marked = 1'b1;
                                sweep = 1'b1;
                            end else begin
                                drop_slot(i);
                                ok = 1'b1;
                            end
                            break;
                        end
                KIND_DEL_ALL: begin
                    i = 0;
                    while (i < count)
                        if (slots[i].id == c.id && !slots[i].marked) begin
                            if (lock) begin
                                slots[i].marked = 1'b1;
                                sweep = 1'b1;
                                i++;
                            end else begin
                                drop_slot(i);
                                ok = 1'b1;
                            end
                        end else
                            i++;
                end
                KIND_CLEAR: begin
                    count = 0;
                    sweep = 0;
                    ok = 1'b1;
                end
                default: ok = 1'b0;
            endcase
            ack(ok);
        endfunction

        function void check_result(sched_res_t got);
            sched_res_t want;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected output transfer fired=%0b id=%0d",
                             got.fired, got.id);
                return;
            end
            want = due_q.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: exp f%0b ok%0b id%0d p%h t%0d s%h c%h l%0b",
                             want.fired, want.ok, want.id, want.param, want.etype,
                             want.stamp, want.clk_now, want.last);
                    $display("       got f%0b ok%0b id%0d p%h t%0d s%h c%h l%0b",
                             got.fired, got.ok, got.id, got.param, got.etype,
                             got.stamp, got.clk_now, got.last);
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [2:0]   s_tuser;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         m_tuser;
    logic [111:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    event_scoreboard sb;
    int  cycles;
    int  checked;
    bit  send_burst;
    bit  recv_burst;

    timed_event_queue_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_cmd(sched_cmd_t c);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = c.kind;
        s_tdata = {5'd0, c.adv, c.offset, c.stamp, c.param, c.id, c.etype};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_cmd(c);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        s_tvalid = 1'b0;
        do
            @(negedge clk);
        while (sb.due_q.size() != 0);
        repeat (300) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic sched_cmd_t mk(logic [2:0] kind, logic [2:0] t, logic [7:0] id,
                                      logic [31:0] p, logic [31:0] s, logic [31:0] off,
                                      logic [31:0] adv);
        mk = '{kind, t, id, p, s, off, adv};
    endfunction

    // mostly near-future adds with few ids and params so deletes hit
    function automatic sched_cmd_t rand_cmd();
        sched_cmd_t c;
        int sel;
        sel = $urandom_range(0, 99);
        c.etype = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
        c.id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        c.param = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
        c.stamp = ($urandom_range(0, 19) == 0) ? $urandom
                                               : sb.clock + $urandom_range(0, 300);
        c.offset = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 200);
        c.adv = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 100000)
                                             : $urandom_range(0, 150);
        if (sel < 50)
            c.kind = KIND_ADD;
        else if (sel < 65)
            c.kind = KIND_DEL_ONE;
        else if (sel < 73)
            c.kind = KIND_DEL_ALL;
        else if (sel < 95)
            c.kind = KIND_ADVANCE;
        else if (sel < 97)
            c.kind = KIND_CLEAR;
        else
            c.kind = 3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
        return c;
    endfunction

    // output side: random stall per transfer outside receive bursts, one long hold-off
    initial
    begin
        bit held;
        sched_res_t r;
        held = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && checked >= 150) begin
                held = 1;
                m_tready = 1'b0;
                repeat (600) @(negedge clk);
            end
            if (!recv_burst)
                begin
                    int stall;
                    stall = $urandom_range(0, 11);
                    m_tready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            r.fired = m_tuser;
            r.ok = m_tdata[0];
            r.id = m_tdata[8:1];
            r.param = m_tdata[40:9];
            r.etype = m_tdata[43:41];
            r.stamp = m_tdata[75:44];
            r.clk_now = m_tdata[107:76];
            r.last = m_tlast;
            sb.check_result(r);
            checked++;
        end
    end

    initial
    begin
        int wait_cycles;
        sb = new();
        sb.init();
        cycles = 0;
        checked = 0;
        send_burst = 0;
        recv_burst = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DELETION_LOCK;
        cfg_data = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every kind, every type, field extremes
        send_cmd(mk(KIND_ADVANCE, EV_ONE_TIME, 0, 0, 0, 0, 0));
        send_cmd(mk(KIND_ADD, EV_ONE_TIME, 8'hFF, MAX_STAMP, 0, MAX_STAMP, 0));
        send_cmd(mk(KIND_ADD, EV_RANGED, 1, 5, 10, 20, 0));
        send_cmd(mk(KIND_ADD, EV_END_RANGE, 2, 6, 10, 7, 0));
        send_cmd(mk(KIND_ADD, EV_PERIODIC, 3, 7, 12, 0, 0));
        send_cmd(mk(KIND_ADD, EV_DAILY, 4, 8, 15, 9, 0));
        send_cmd(mk(KIND_ADD, 3'd7, 5, 9, 15, 9, 0));
        send_cmd(mk(KIND_ADD, EV_PERIODIC, 6, 1, MAX_STAMP - 2, 5, 0));
        send_cmd(mk(KIND_DEL_ONE, 0, 2, 6, 0, 0, 0));
        send_cmd(mk(KIND_DEL_ONE, 0, 2, 6, 0, 0, 0));
        send_cmd(mk(KIND_DEL_ALL, 0, 9, 0, 0, 0, 0));
        send_cmd(mk(KIND_ADVANCE, 0, 0, 0, 0, 0, 100));
        send_cmd(mk(KIND_ADVANCE, 0, 0, 0, 0, 0, 100000));
        send_cmd(mk(KIND_ADD, EV_ONE_TIME, 7, 0, 5, 0, 0));
        send_cmd(mk(KIND_ADVANCE, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(KIND_BAD_LO, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(KIND_BAD_HI, 3'd7, 8'hFF, MAX_STAMP, MAX_STAMP, MAX_STAMP, MAX_STAMP));
        send_cmd(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
        // full queue, refused add, then the per-advance result cap
        send_burst = 1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_cmd(mk(KIND_ADD, EV_PERIODIC, 8'(i), 32'(i), sb.clock + 1, 1, 0));
        send_cmd(mk(KIND_ADD, EV_ONE_TIME, 1, 1, 0, 0, 0));
        send_burst = 0;
        send_cmd(mk(KIND_ADVANCE, 0, 0, 0, 0, 0, 10));
        send_cmd(mk(KIND_ADVANCE, 0, 0, 0, 0, 0, 1));
        send_cmd(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_DELETION_LOCK, 32'd1);
                    write_reg(REG_SECONDS_PER_DAY, 32'd1);
                end
                1: begin
                    write_reg(REG_DELETION_LOCK, 32'd0);
                    write_reg(REG_SECONDS_PER_DAY, MAX_STAMP);
                end
                2: begin
                    write_reg(REG_DELETION_LOCK, 32'd1);
                    write_reg(REG_SECONDS_PER_DAY, $urandom_range(2, 500));
                end
                default: begin
                    write_reg(REG_DELETION_LOCK, 32'd0);
                    write_reg(REG_SECONDS_PER_DAY, DAY_RESET);
                end
            endcase
            for (int n = 0; n < 95; n++) begin
                if (n % 30 == 0) begin
                    send_burst = $urandom_range(0, 2) == 0;
                    recv_burst = $urandom_range(0, 2) == 0;
                end
                send_cmd(rand_cmd());
            end
        end
        send_burst = 0;
        recv_burst = 0;
        // saturating advance last, since the clock never moves back
        send_cmd(mk(KIND_ADVANCE, 0, 0, 0, 0, 0, MAX_STAMP));
        s_tvalid = 1'b0;

        wait_cycles = 0;
        while (sb.due_q.size() != 0 && wait_cycles < 200000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (300) @(negedge clk);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/teq_pkg.sv
rtl/core/teq_cell.sv
rtl/core/timed_event_queue_core.sv
rtl/core/teq_checker.sv
dv/timed_event_queue_core_tb.sv
